>>> rtl/core/fpr_pkg.sv
package fpr_pkg;

    localparam int MAX_FRAMES = 8;
    localparam int PAGE_BITS  = 16;
    localparam int AGE_BITS   = 16;

    // Frame address and frame count widths.
    localparam int IDX_W   = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int CNT_W   = $clog2(MAX_FRAMES + 1);
    localparam int ENTRY_W = PAGE_BITS + AGE_BITS;

    // Fixed widths of the item fields.
    localparam int CFG_W     = 4;
    localparam int PAGE_W    = 16;
    localparam int OUTCOME_W = 2;
    localparam int FIDX_W    = 3;
    localparam int HITS_W    = 32;

    localparam logic [AGE_BITS-1:0] AGE_ZERO = '0;
    localparam logic [AGE_BITS-1:0] AGE_ONE  = AGE_BITS'(1);
    localparam logic [AGE_BITS-1:0] AGE_MAX  = '1;

    localparam logic [CFG_W-1:0] FRAMES_RESET = CFG_W'(4);

    localparam logic [OUTCOME_W-1:0] OUTCOME_HIT     = 2'd0;
    localparam logic [OUTCOME_W-1:0] OUTCOME_FILL    = 2'd1;
    localparam logic [OUTCOME_W-1:0] OUTCOME_REPLACE = 2'd2;

    typedef struct packed {
        logic [PAGE_BITS-1:0] page;
        logic [CNT_W-1:0]     frames;
    } fpr_req_t;

    typedef struct packed {
        logic [OUTCOME_W-1:0] outcome;
        logic [FIDX_W-1:0]    frame_index;
        logic [PAGE_W-1:0]    evicted_page;
        logic [HITS_W-1:0]    hit_count;
    } fpr_res_t;

endpackage

>>> rtl/core/fpr_engine.sv
module fpr_engine (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              req_valid,
    input  fpr_pkg::fpr_req_t req,
    output logic              req_ready,
    output logic              res_valid,
    output fpr_pkg::fpr_res_t res,
    input  logic              res_ready
);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_UPD   = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    // Frame table: page number in the upper bits, age in the lower bits.
    logic [fpr_pkg::ENTRY_W-1:0] mem [fpr_pkg::MAX_FRAMES];

    logic [2:0]                    state_reg, state_next;
    logic [fpr_pkg::CNT_W-1:0]     issue_cnt_reg, issue_cnt_next;
    logic [fpr_pkg::CNT_W-1:0]     n_reg, n_next;
    logic [fpr_pkg::PAGE_BITS-1:0] page_reg, page_next;
    logic                          hit_reg, hit_next;
    logic [fpr_pkg::IDX_W-1:0]     hit_idx_reg, hit_idx_next;
    logic [fpr_pkg::IDX_W-1:0]     victim_reg, victim_next;
    logic [fpr_pkg::AGE_BITS-1:0]  best_age_reg, best_age_next;
    logic [fpr_pkg::PAGE_BITS-1:0] victim_page_reg, victim_page_next;
    logic [fpr_pkg::HITS_W-1:0]    hit_total_reg, hit_total_next;
    logic                          rd_valid_reg, rd_valid_next;
    logic [fpr_pkg::IDX_W-1:0]     rd_idx_reg, rd_idx_next;
    logic [fpr_pkg::ENTRY_W-1:0]   rd_data_reg;

    logic                          mem_we, mem_re;
    logic [fpr_pkg::IDX_W-1:0]     mem_waddr, mem_raddr;
    logic [fpr_pkg::ENTRY_W-1:0]   mem_wdata;

    logic [fpr_pkg::PAGE_BITS-1:0] entry_page;
    logic [fpr_pkg::AGE_BITS-1:0]  entry_age;
    logic                          match;
    logic                          last_entry;
    logic                          issue_more;

    assign entry_page = rd_data_reg[fpr_pkg::ENTRY_W-1 -: fpr_pkg::PAGE_BITS];
    assign entry_age  = rd_data_reg[fpr_pkg::AGE_BITS-1:0];
    assign match      = (page_reg != '0) && (entry_page == page_reg) && !hit_reg;
    assign last_entry = (fpr_pkg::CNT_W'(rd_idx_reg) == n_reg - fpr_pkg::CNT_W'(1));
    assign issue_more = (issue_cnt_reg < n_reg);

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    always_comb begin
        state_next       = state_reg;
        issue_cnt_next   = issue_cnt_reg;
        n_next           = n_reg;
        page_next        = page_reg;
        hit_next         = hit_reg;
        hit_idx_next     = hit_idx_reg;
        victim_next      = victim_reg;
        best_age_next    = best_age_reg;
        victim_page_next = victim_page_reg;
        hit_total_next   = hit_total_reg;
        rd_valid_next    = 1'b0;
        rd_idx_next      = issue_cnt_reg[fpr_pkg::IDX_W-1:0];
        mem_we           = 1'b0;
        mem_re           = 1'b0;
        mem_waddr        = rd_idx_reg;
        mem_wdata        = rd_data_reg;
        mem_raddr        = issue_cnt_reg[fpr_pkg::IDX_W-1:0];
        req_ready        = 1'b0;
        res_valid        = 1'b0;

        unique case (state_reg)
            ST_CLEAR: begin
                mem_we         = 1'b1;
                mem_waddr      = issue_cnt_reg[fpr_pkg::IDX_W-1:0];
                mem_wdata      = {{fpr_pkg::PAGE_BITS{1'b0}}, fpr_pkg::AGE_ONE};
                issue_cnt_next = issue_cnt_reg + fpr_pkg::CNT_W'(1);
                if (issue_cnt_reg == fpr_pkg::CNT_W'(fpr_pkg::MAX_FRAMES - 1)) begin
                    issue_cnt_next = '0;
                    state_next     = ST_IDLE;
                end
            end
            ST_IDLE: begin
                req_ready = 1'b1;
                if (req_valid) begin
                    page_next        = req.page;
                    n_next           = req.frames;
                    hit_next         = 1'b0;
                    hit_idx_next     = '0;
                    victim_next      = '0;
                    best_age_next    = '0;
                    victim_page_next = '0;
                    issue_cnt_next   = '0;
                    state_next       = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (issue_more) begin
                    mem_re         = 1'b1;
                    rd_valid_next  = 1'b1;
                    issue_cnt_next = issue_cnt_reg + fpr_pkg::CNT_W'(1);
                end
                if (rd_valid_reg) begin
                    if (match) begin
                        hit_next     = 1'b1;
                        hit_idx_next = rd_idx_reg;
                    end
                    if ((rd_idx_reg == '0) || (entry_age > best_age_reg)) begin
                        best_age_next    = entry_age;
                        victim_next      = rd_idx_reg;
                        victim_page_next = entry_page;
                    end
                    if (last_entry) begin
                        issue_cnt_next = '0;
                        state_next     = ST_UPD;
                        if (hit_reg || match) begin
                            hit_total_next = hit_total_reg + fpr_pkg::HITS_W'(1);
                        end
                    end
                end
            end
            ST_UPD: begin
                if (issue_more) begin
                    mem_re         = 1'b1;
                    rd_valid_next  = 1'b1;
                    issue_cnt_next = issue_cnt_reg + fpr_pkg::CNT_W'(1);
                end
                if (rd_valid_reg) begin
                    mem_we = 1'b1;
                    if (hit_reg && (rd_idx_reg == hit_idx_reg)) begin
                        mem_wdata = rd_data_reg;
                    end else if (!hit_reg && (rd_idx_reg == victim_reg)) begin
                        mem_wdata = {page_reg, fpr_pkg::AGE_ZERO};
                    end else if (entry_age == fpr_pkg::AGE_MAX) begin
                        mem_wdata = rd_data_reg;
                    end else begin
                        mem_wdata = {entry_page, entry_age + fpr_pkg::AGE_BITS'(1)};
                    end
                    if (last_entry) begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        res.hit_count = hit_total_reg;
        if (hit_reg) begin
            res.outcome      = fpr_pkg::OUTCOME_HIT;
            res.frame_index  = fpr_pkg::FIDX_W'(hit_idx_reg);
            res.evicted_page = '0;
        end else begin
            res.frame_index  = fpr_pkg::FIDX_W'(victim_reg);
            res.evicted_page = fpr_pkg::PAGE_W'(victim_page_reg);
            res.outcome      = (victim_page_reg == '0) ? fpr_pkg::OUTCOME_FILL
                                                        : fpr_pkg::OUTCOME_REPLACE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            issue_cnt_reg <= '0;
            hit_total_reg <= '0;
            rd_valid_reg  <= 1'b0;
            n_reg         <= fpr_pkg::CNT_W'(1);
            hit_reg       <= 1'b0;
        end else begin
            state_reg     <= state_next;
            issue_cnt_reg <= issue_cnt_next;
            hit_total_reg <= hit_total_next;
            rd_valid_reg  <= rd_valid_next;
            n_reg         <= n_next;
            hit_reg       <= hit_next;
        end
    end

    always_ff @(posedge aclk) begin
        page_reg        <= page_next;
        hit_idx_reg     <= hit_idx_next;
        victim_reg      <= victim_next;
        best_age_reg    <= best_age_next;
        victim_page_reg <= victim_page_next;
        rd_idx_reg      <= rd_idx_next;
    end

    // The write-back of one frame never lands on the frame being read.
    a_no_rw_collision: assert property (@(posedge aclk) disable iff (!aresetn)
        (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
        else $error("frame table read and write hit the same entry");

    // Reads never run past the frames taking part.
    a_issue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_SCAN) || (state_reg == ST_UPD)) |->
            ((issue_cnt_reg <= n_reg) && (n_reg != '0)))
        else $error("frame read counter beyond frame count");

    // Read data is only in flight during the two passes.
    a_rd_in_pass: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_valid_reg |-> ((state_reg == ST_SCAN) || (state_reg == ST_UPD)))
        else $error("frame read returned outside a pass");

    // The hit total moves only at the end of a lookup pass.
    a_hits_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_SCAN) |=> $stable(hit_total_reg))
        else $error("hit total changed outside lookup");

endmodule

>>> rtl/core/fifo_page_replacement.sv
// FIFO page replacement over up to eight physical frames.
//
// Input channel (s_valid/s_ready, s_page_number): one page reference per item.
// Result channel (m_valid/m_ready): one result item per reference, giving the
// outcome (hit, fill of an empty frame or replacement), the frame that hit or
// now holds the page, the evicted page and the running hit count.
// Configuration channel (cfg_valid/cfg_ready, cfg_data): sets the number of
// frames in use; it is always ready and should only be written while idle.
//
// Each reference makes two passes over the frame table memory through its
// single read port, one lookup/victim pass and one aging write-back pass.
// The engine takes a new item only after the previous one has finished both
// passes and handed its result on, so references do not overlap. The memory
// port and its registered read set the pace of each pass.
//
// After reset the frame table is cleared (all frames empty, age one) while
// s_ready stays low; the frame count returns to four and the hit count to
// zero. A finished result sits in the output register, so the engine takes
// the next item while the receiver stalls; only when a second result is ready
// and the first is still waiting does the engine hold.
module fifo_page_replacement (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [fpr_pkg::CFG_W-1:0]         cfg_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [fpr_pkg::PAGE_W-1:0]        s_page_number,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [fpr_pkg::OUTCOME_W-1:0]     m_outcome,
    output logic [fpr_pkg::FIDX_W-1:0]        m_frame_index,
    output logic [fpr_pkg::PAGE_W-1:0]        m_evicted_page,
    output logic [fpr_pkg::HITS_W-1:0]        m_hit_count
);

    logic [fpr_pkg::CFG_W-1:0] frames_reg;
    logic [fpr_pkg::CNT_W-1:0] frames_eff;
    fpr_pkg::fpr_req_t         req;
    fpr_pkg::fpr_res_t         res;
    logic                      res_valid;
    logic                      res_ready;
    logic                      m_valid_reg;
    fpr_pkg::fpr_res_t         out_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frames_reg <= fpr_pkg::FRAMES_RESET;
        end else if (cfg_valid) begin
            frames_reg <= cfg_data;
        end
    end

    // A frame count of zero acts as one; anything above the table acts as full.
    always_comb begin
        if (frames_reg == '0) begin
            frames_eff = fpr_pkg::CNT_W'(1);
        end else if (int'(frames_reg) > fpr_pkg::MAX_FRAMES) begin
            frames_eff = fpr_pkg::CNT_W'(fpr_pkg::MAX_FRAMES);
        end else begin
            frames_eff = fpr_pkg::CNT_W'(frames_reg);
        end
    end

    assign req.page   = fpr_pkg::PAGE_BITS'(s_page_number);
    assign req.frames = frames_eff;

    fpr_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_valid),
        .req       (req),
        .req_ready (s_ready),
        .res_valid (res_valid),
        .res       (res),
        .res_ready (res_ready)
    );

    // Output register: loads whenever it is empty or being drained.
    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_outcome      = out_reg.outcome;
    assign m_frame_index  = out_reg.frame_index;
    assign m_evicted_page = out_reg.evicted_page;
    assign m_hit_count    = out_reg.hit_count;

endmodule

>>> bench/tb_fifo_page_replacement.sv
module tb_fifo_page_replacement;

    // The limit leaves a wide margin over the length of a correct run, even with
    // the longest gaps and stalls on every item.
    localparam int CYCLE_LIMIT = 200_000;

    // Quiet cycles after the last result.
    localparam int SETTLE_CYCLES = 40;

    // Tracks the frame table the same way the engine should. Each accepted
    // reference is turned into the result it must produce. Those results wait in
    // order until the result channel delivers its items.
    class frame_table_tracker;
        logic [fpr_pkg::PAGE_BITS-1:0] frame_page [fpr_pkg::MAX_FRAMES];
        logic [fpr_pkg::AGE_BITS-1:0]  frame_age  [fpr_pkg::MAX_FRAMES];
        logic [fpr_pkg::HITS_W-1:0]    hit_total;
        logic [fpr_pkg::CFG_W-1:0]     frames_in_use;
        fpr_pkg::fpr_res_t             awaited[$];
        int                            errors;

        function new();
            for (int i = 0; i < fpr_pkg::MAX_FRAMES; i++) begin
                frame_page[i] = '0;
                frame_age[i]  = fpr_pkg::AGE_ONE;
            end
            hit_total     = '0;
            frames_in_use = fpr_pkg::FRAMES_RESET;
            errors        = 0;
        endfunction

        // A count of zero still uses one frame. Counts above the table size are
        // clamped to the table size.
        function int active_frames();
            int n;
            n = int'(frames_in_use);
            if (n < 1) n = 1;
            if (n > fpr_pkg::MAX_FRAMES) n = fpr_pkg::MAX_FRAMES;
            return n;
        endfunction

        function void set_frames(logic [fpr_pkg::CFG_W-1:0] value);
            frames_in_use = value;
        endfunction

        function void note_reference(logic [fpr_pkg::PAGE_W-1:0] page);
            int                           n;
            int                           target;
            int                           victim;
            bit                           hit;
            logic [fpr_pkg::AGE_BITS-1:0] best_age;
            fpr_pkg::fpr_res_t            res;
            n        = active_frames();
            hit      = 1'b0;
            target   = 0;
            victim   = 0;
            best_age = frame_age[0];
            res      = '0;
            // Page zero never matches, not even an empty frame. Otherwise the
            // lowest matching frame wins.
            if (page != '0) begin
                for (int i = 0; i < n; i++) begin
                    if (!hit && frame_page[i] == page) begin
                        hit    = 1'b1;
                        target = i;
                    end
                end
            end
            // The victim is chosen on the ages before this reference. Only a strictly
            // larger age displaces a lower index.
            for (int i = 1; i < n; i++) begin
                if (frame_age[i] > best_age) begin
                    best_age = frame_age[i];
                    victim   = i;
                end
            end
            for (int i = 0; i < n; i++) begin
                if (!(hit && i == target) && frame_age[i] != fpr_pkg::AGE_MAX)
                    frame_age[i] = frame_age[i] + 1'b1;
            end
            if (hit) begin
                hit_total   = hit_total + 1'b1;
                res.outcome = fpr_pkg::OUTCOME_HIT;
            end else begin
                target = victim;
                if (frame_page[victim] == '0) begin
                    res.outcome = fpr_pkg::OUTCOME_FILL;
                end else begin
                    res.outcome      = fpr_pkg::OUTCOME_REPLACE;
                    res.evicted_page = frame_page[victim];
                end
                frame_page[victim] = page;
                frame_age[victim]  = fpr_pkg::AGE_ZERO;
            end
            res.frame_index = target[fpr_pkg::FIDX_W-1:0];
            res.hit_count   = hit_total;
            awaited.insert(awaited.size(), res);
        endfunction

        function void compare_field(string field, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
                errors++;
            end
        endfunction

        function void check_result(fpr_pkg::fpr_res_t got);
            fpr_pkg::fpr_res_t want;
            if (awaited.size() == 0) begin
                $display("%0t: result with no reference waiting, expected none, actual %0h",
                         $time, got);
                errors++;
                return;
            end
            want = awaited[0];
            awaited.delete(0);
            compare_field("outcome", 32'(want.outcome), 32'(got.outcome));
            compare_field("frame_index", 32'(want.frame_index), 32'(got.frame_index));
            compare_field("evicted_page", 32'(want.evicted_page), 32'(got.evicted_page));
            compare_field("hit_count", want.hit_count, got.hit_count);
        endfunction
    endclass

    logic                          aclk;
    logic                          aresetn;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [fpr_pkg::CFG_W-1:0]     cfg_data;
    logic                          s_valid;
    logic                          s_ready;
    logic [fpr_pkg::PAGE_W-1:0]    s_page_number;
    logic                          m_valid;
    logic                          m_ready;
    logic [fpr_pkg::OUTCOME_W-1:0] m_outcome;
    logic [fpr_pkg::FIDX_W-1:0]    m_frame_index;
    logic [fpr_pkg::PAGE_W-1:0]    m_evicted_page;
    logic [fpr_pkg::HITS_W-1:0]    m_hit_count;

    frame_table_tracker tracker = new();

    // Traffic shaping. The sender sends bursts of burst_left items, and the gap
    // before each burst is at most gap_max cycles. stall_level sets how often the
    // receiver stalls, from never (0) to most often (3).
    int          gap_max     = 0;
    int          burst_left  = 0;
    logic [1:0]  stall_level = 2'd0;
    logic [31:0] stall_bits  = '0;
    int          stall_left  = 0;
    int          cycle_count = 0;

    // Pages that the random phases reference most often, so that hits and
    // replacements both occur regularly.
    logic [fpr_pkg::PAGE_W-1:0] working_set [fpr_pkg::MAX_FRAMES + 2];
    int                         working_size = 1;

    fifo_page_replacement uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_page_number  (s_page_number),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_outcome      (m_outcome),
        .m_frame_index  (m_frame_index),
        .m_evicted_page (m_evicted_page),
        .m_hit_count    (m_hit_count)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // All handshakes are observed here at the rising edge. The result is checked
    // before the new reference is noted. A result never belongs to the reference
    // accepted at the same edge, so this order is safe.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready)
                tracker.check_result('{outcome: m_outcome, frame_index: m_frame_index,
                                       evicted_page: m_evicted_page,
                                       hit_count: m_hit_count});
            if (s_valid && s_ready)
                tracker.note_reference(s_page_number);
            if (cfg_valid && cfg_ready)
                tracker.set_frames(cfg_data);
        end
    end

    // The receiver stalls according to a random bit pattern that is reloaded once
    // its sixteen bits are used up. Each cycle takes two bits of the pattern, and
    // stall_level sets the threshold those bits must reach for m_ready to be high.
    always @(negedge aclk) begin
        if (stall_left == 0) begin
            stall_bits = $urandom;
            stall_left = 16;
        end
        m_ready    = (stall_bits[1:0] >= stall_level);
        stall_bits = stall_bits >> 2;
        stall_left = stall_left - 2;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    // Presents one page reference and returns at the falling edge after it is
    // accepted. Valid stays high across a burst. It drops only for a gap.
    task automatic send_page(input logic [fpr_pkg::PAGE_W-1:0] page);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, gap_max);
            if (gap > 0) begin
                s_valid = 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 12);
        end
        s_valid       = 1'b1;
        s_page_number = page;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        burst_left--;
    endtask

    // Holds the sender off until every outstanding result has been delivered.
    task automatic wait_drained();
        s_valid    = 1'b0;
        burst_left = 0;
        while (tracker.awaited.size() != 0) @(negedge aclk);
    endtask

    // The frame count is changed only while the engine is idle.
    task automatic write_frames(input logic [fpr_pkg::CFG_W-1:0] value);
        wait_drained();
        cfg_data  = value;
        cfg_valid = 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // Mostly pages from the working set. Fully random pages, page zero, all ones
    // and single-bit pages make up the rest.
    function automatic logic [fpr_pkg::PAGE_W-1:0] pick_page();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70) return working_set[$urandom_range(0, working_size - 1)];
        if (roll < 85) return fpr_pkg::PAGE_W'($urandom_range(1, 65535));
        if (roll < 90) return '0;
        if (roll < 95) return '1;
        return fpr_pkg::PAGE_W'(1) << $urandom_range(0, fpr_pkg::PAGE_W - 1);
    endfunction

    initial begin
        int                         frame_plan [12];
        logic [fpr_pkg::PAGE_W-1:0] shared_page;
        frame_plan = '{0, 1, 2, 3, 5, 6, 7, 8, 9, 12, 15, 4};

        aresetn       = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        s_valid       = 1'b0;
        s_page_number = '0;
        m_ready       = 1'b0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed part. It starts at the reset frame count of four. The engine
        // spends its first cycles clearing the table, so s_ready is low at first.
        gap_max     = 3;
        stall_level = 2'd1;
        send_page(16'h0001);    // fill of an empty frame
        send_page(16'h0001);    // hit
        send_page(16'hFFFF);    // largest page
        send_page(16'h0000);    // page zero is a miss and leaves its frame empty
        send_page(16'h8000);
        send_page(16'h5555);
        send_page(16'hAAAA);    // the oldest frame holds a page, so this replaces it
        send_page(16'h0001);

        // All eight frames, and then a count above the table size.
        write_frames(4'd8);
        for (int i = 2; i < 6; i++) send_page(fpr_pkg::PAGE_W'(i));
        write_frames(4'd15);
        send_page(16'h0002);
        send_page(16'h7777);

        // A count of zero acts as one frame, so every new page replaces frame zero.
        write_frames(4'd0);
        send_page(16'h1111);
        send_page(16'h2222);

        // Duplicate resident page. A page is placed in frame one. The count is then
        // shrunk to one and the same page is referenced, which copies it into frame
        // zero. After the count grows back, the lower frame must take the hit.
        write_frames(4'd2);
        send_page(16'h0303);
        send_page(16'h0404);
        wait_drained();
        shared_page = tracker.frame_page[1];
        write_frames(4'd1);
        send_page(shared_page);
        write_frames(4'd2);
        send_page(shared_page);

        // Aging at full rate. Page B is hit while page A ages, and then A is hit
        // while B's frame ages past A's. The next miss must go to B's frame.
        gap_max     = 0;
        stall_level = 2'd0;
        send_page(16'h0A0A);
        send_page(16'h0B0B);
        repeat (12) send_page(16'h0B0B);
        repeat (20) send_page(16'h0A0A);
        send_page(16'h0C0C);

        // Random phases. Each phase has its own frame count and working set. Every
        // fourth phase runs with no idling on either side. Some phases drain
        // completely in the middle.
        for (int phase = 0; phase < 12; phase++) begin
            write_frames(fpr_pkg::CFG_W'(frame_plan[phase]));
            if (phase % 4 == 0) begin
                gap_max     = 0;
                stall_level = 2'd0;
            end else begin
                gap_max     = $urandom_range(1, 30);
                stall_level = 2'($urandom_range(0, 3));
            end
            working_size = tracker.active_frames() + $urandom_range(0, 2);
            for (int j = 0; j < working_size; j++)
                working_set[j] = fpr_pkg::PAGE_W'($urandom_range(1, 65535));
            for (int k = 0; k < 50; k++) begin
                if (k == 25 && phase % 3 == 1) wait_drained();
                send_page(pick_page());
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (tracker.errors == 0 && tracker.awaited.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
